// ===== rtl/core/aun_pkg.sv =====
// Shared types and constants for the Arabic UTF-8 normaliser.
// Holds the channel words, the internal command word and the pair rule.
// Depends on nothing; every other file refers to it by scoped names.
package aun_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_text;
        logic       run_end;
    } out_word_t;

    // One command holds every result caused by one input word, first byte in data[0].
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            has_byte;
        logic            eot;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PAIR,
        PH_THREE0,
        PH_THREE1,
        PH_FOUR0,
        PH_FOUR1,
        PH_FOUR2
    } phase_t;

    typedef struct packed {
        logic       keep;
        logic [7:0] b0;
        logic [7:0] b1;
    } pair_t;

    localparam logic [10:0] CP_DROP_LO   = 11'h64B;
    localparam logic [10:0] CP_DROP_HI   = 11'h652;
    localparam logic [10:0] CP_SUPERALEF = 11'h670;
    localparam logic [10:0] CP_TATWEEL   = 11'h640;
    localparam logic [10:0] CP_ALEF_HAMZA_ABOVE = 11'h623;
    localparam logic [10:0] CP_ALEF_HAMZA_BELOW = 11'h625;
    localparam logic [10:0] CP_ALEF_MADDA = 11'h622;
    localparam logic [10:0] CP_ALEF_WASLA = 11'h671;
    localparam logic [10:0] CP_ALEF       = 11'h627;
    localparam logic [10:0] CP_ALEF_MAKSURA = 11'h649;
    localparam logic [10:0] CP_YEH_HAMZA  = 11'h626;
    localparam logic [10:0] CP_YEH        = 11'h64A;

    function automatic logic is_two_lead(input logic [7:0] b);
        return (b & 8'hE0) == 8'hC0;
    endfunction

    // Decodes a lead and the byte after it with no continuation check and applies
    // the drop and remap rules.
    function automatic pair_t do_pair(input logic [7:0] lead, input logic [7:0] next);
        logic [10:0] cp;
        logic [10:0] to;
        pair_t       r;
        cp = {lead[4:0], next[5:0]};
        to = '0;
        r.keep = 1'b1;
        r.b0   = lead;
        r.b1   = next;
        if ((cp >= CP_DROP_LO && cp <= CP_DROP_HI) || cp == CP_SUPERALEF
            || cp == CP_TATWEEL) begin
            r.keep = 1'b0;
        end
        else if (cp == CP_ALEF_HAMZA_ABOVE || cp == CP_ALEF_HAMZA_BELOW
                 || cp == CP_ALEF_MADDA || cp == CP_ALEF_WASLA) begin
            to = CP_ALEF;
        end
        else if (cp == CP_ALEF_MAKSURA || cp == CP_YEH_HAMZA) begin
            to = CP_YEH;
        end
        if (to != '0) begin
            r.b0 = {3'b110, to[10:6]};
            r.b1 = {2'b10, to[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/aun_front.sv =====
// Front end: accepts input words, tracks the sequence phase and builds one command.
// Depends on aun_pkg.
module aun_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aun_pkg::in_word_t in_word,
    input  logic              q_full,
    output logic              push,
    output aun_pkg::cmd_t     push_cmd
);

    aun_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      lead_reg, lead_next;
    logic [7:0]      held_reg [2];
    logic [7:0]      held0_next, held1_next;
    logic            accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aun_pkg::PH_IDLE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lead_reg    <= lead_next;
            held_reg[0] <= held0_next;
            held_reg[1] <= held1_next;
        end
    end

    always_comb
    begin
        logic [7:0]     b;
        logic           fin;
        aun_pkg::pair_t p;
        aun_pkg::cmd_t  c;
        b   = in_word.in_byte;
        fin = in_word.is_final;
        p   = '0;
        c   = '0;
        c.has_byte  = 1'b1;
        phase_next  = aun_pkg::PH_IDLE;
        lead_next   = lead_reg;
        held0_next  = held_reg[0];
        held1_next  = held_reg[1];
        unique case (phase_reg)
            aun_pkg::PH_PAIR:
            begin
                p = aun_pkg::do_pair(lead_reg, b);
                c.data[0] = p.b0;
                c.data[1] = p.b1;
                c.count   = p.keep ? 2'd2 : 2'd0;
            end
            aun_pkg::PH_THREE0, aun_pkg::PH_FOUR0:
            begin
                if (fin)
                begin
                    c.data[0] = b;
                    c.count   = 2'd1;
                end
                else
                begin
                    held0_next = b;
                    phase_next = (phase_reg == aun_pkg::PH_THREE0) ?
                                 aun_pkg::PH_THREE1 : aun_pkg::PH_FOUR1;
                end
            end
            aun_pkg::PH_THREE1:
            begin
                c.data[0] = held_reg[0];
                c.data[1] = b;
                c.count   = 2'd2;
            end
            aun_pkg::PH_FOUR1:
            begin
                if (fin)
                begin
                    // A truncated tail is run through the ordinary rules again.
                    if (aun_pkg::is_two_lead(held_reg[0]))
                    begin
                        p = aun_pkg::do_pair(held_reg[0], b);
                        c.data[0] = p.b0;
                        c.data[1] = p.b1;
                        c.count   = p.keep ? 2'd2 : 2'd0;
                    end
                    else
                    begin
                        c.data[0] = held_reg[0];
                        c.data[1] = b;
                        c.count   = 2'd2;
                    end
                end
                else
                begin
                    held1_next = b;
                    phase_next = aun_pkg::PH_FOUR2;
                end
            end
            aun_pkg::PH_FOUR2:
            begin
                c.data[0] = held_reg[0];
                c.data[1] = held_reg[1];
                c.data[2] = b;
                c.count   = 2'd3;
            end
            default:
            begin
                c.data[0] = b;
                c.count   = 2'd1;
                if (!fin && b[7])
                begin
                    if (aun_pkg::is_two_lead(b))
                    begin
                        lead_next  = b;
                        phase_next = aun_pkg::PH_PAIR;
                        c.count    = 2'd0;
                    end
                    else if ((b & 8'hF0) == 8'hE0)
                    begin
                        phase_next = aun_pkg::PH_THREE0;
                    end
                    else if ((b & 8'hF8) == 8'hF0)
                    begin
                        phase_next = aun_pkg::PH_FOUR0;
                    end
                end
            end
        endcase
        if (fin)
        begin
            phase_next = aun_pkg::PH_IDLE;
            if (c.count == 2'd0)
            begin
                c.data     = '0;
                c.count    = 2'd1;
                c.has_byte = 1'b0;
            end
        end
        c.eot    = fin;
        push_cmd = c;
        push     = accept && (c.count != 2'd0);
    end

endmodule

// ===== rtl/core/aun_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on aun_pkg for the command word.
module aun_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  aun_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output aun_pkg::cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aun_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/aun_back.sv =====
// Back end: holds one command and hands out its bytes one word per cycle while out_ready is high.
// Depends on aun_pkg.
module aun_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  aun_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output aun_pkg::out_word_t out_word
);

    aun_pkg::cmd_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          last;

    assign last      = idx_reg == (cur_reg.count - 2'd1);
    assign out_valid = cur_valid_reg;
    assign pop       = q_not_empty && (!cur_valid_reg || (out_ready && last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (cur_valid_reg && out_ready)
        begin
            if (last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        out_word.out_byte    = cur_reg.data[idx_reg];
        out_word.has_byte    = cur_reg.has_byte;
        out_word.end_of_text = cur_reg.eot && last;
        out_word.run_end     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
    end

endmodule

// ===== rtl/core/arabic_utf8_normalizer.sv =====
// Top level of the Arabic UTF-8 normaliser: front end, command queue, back end.
// Depends on aun_pkg, aun_front, aun_queue and aun_back.
//
//   Channel   Direction  Handshake             Word
//   input     in         in_valid / in_ready   aun_pkg::in_word_t (byte, final flag)
//   output    out        out_valid / out_ready aun_pkg::out_word_t (byte, flags)
//
// Each input word is turned into a command of up to three result bytes; the back
// end delivers one result word per cycle while out_ready is high, so the sustained
// rate is one word per cycle, set by the single output port of the back end.
// A word that causes no result still takes one queue check but no queue slot.
// in_ready drops only while the command queue of QUEUE_DEPTH entries is full.
// Reset clears the phase, the queue pointers and the output valid; byte stores
// are loaded before they are read and need no reset.
module arabic_utf8_normalizer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aun_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output aun_pkg::out_word_t out_word
);

    // The front end writes a command only when the word yields at least one result or is final.
    logic          q_full;
    logic          push;
    aun_pkg::cmd_t push_cmd;
    logic          pop;
    logic          q_not_empty;
    aun_pkg::cmd_t head_cmd;

    aun_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // The queue lets the front end carry on while a long command is drained.
    aun_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // The back end's held command is the output register of the block.
    aun_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

endmodule

// ===== rtl/core/aun_checker.sv =====
// Port-level checks for the Arabic UTF-8 normaliser, bound to its top level.
// Depends on aun_pkg and on the port list of arabic_utf8_normalizer.
module aun_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input aun_pkg::in_word_t  in_word,
    input logic               out_valid,
    input logic               out_ready,
    input aun_pkg::out_word_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word changed while stalled");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.has_byte |->
            out_word.end_of_text && out_word.run_end && out_word.out_byte == 8'h00)
        else $error("bare word that is not a clean end marker");

    a_eot_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.end_of_text |-> out_word.run_end)
        else $error("end of text before end of run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_word.run_end |=> out_valid)
        else $error("gap inside the results of one input word");

endmodule

bind arabic_utf8_normalizer aun_checker u_aun_checker (.*);
